// File: rtl/protobuf_wire_tokenizer_top_assert.svh
// Assertion macros for the wire tokenizer checker
`ifndef PROTOBUF_WIRE_TOKENIZER_TOP_ASSERT_SVH
`define PROTOBUF_WIRE_TOKENIZER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PWT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define PWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: rtl/pbwt_pkg.sv
// ----------------------------------------------------------------------------
// pbwt_pkg
// Types and codes shared by the wire tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none
package pbwt_pkg;
   typedef enum logic [2:0] {
      PH_KEY     = 3'd0,
      PH_VARINT  = 3'd1,
      PH_LENGTH  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_FIXED   = 3'd4,
      PH_ERROR   = 3'd5
   } phase_type;

   localparam logic [2:0] TK_NONE    = 3'd0;
   localparam logic [2:0] TK_KEY     = 3'd1;
   localparam logic [2:0] TK_VARINT  = 3'd2;
   localparam logic [2:0] TK_LENGTH  = 3'd3;
   localparam logic [2:0] TK_PAYLOAD = 3'd4;
   localparam logic [2:0] TK_FIXED   = 3'd5;
   localparam logic [2:0] TK_ERROR   = 3'd6;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_OVERFLOW = 3'd1;
   localparam logic [2:0] ERR_FIELD    = 3'd2;
   localparam logic [2:0] ERR_WIRE     = 3'd3;
   localparam logic [2:0] ERR_TRUNC    = 3'd4;

   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   typedef struct packed {
      logic [2:0]  token_kind;
      logic [28:0] field_number;
      logic [2:0]  wire_code;
      logic [63:0] value;
      logic [7:0]  data_byte;
      logic        field_end;
      logic [2:0]  error_code;
      logic        message_done;
   } token_type;
endpackage
`default_nettype wire

// File: rtl/protobuf_wire_tokenizer_top.sv
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer_top
// A token is readable from the queue in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the queue is not full; the varint/key decoder is combinational.
// A two-entry token queue decouples the decoder from the result port.
// Reset: synchronous; decoder returns to key phase and the queue empties.
// ----------------------------------------------------------------------------
`default_nettype none
module protobuf_wire_tokenizer_top #(
   parameter logic [28:0] MAX_FIELD_NUMBER = 29'd536870911,
   parameter logic [31:0] MAX_MESSAGE_BYTES = 32'd65535
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_message,
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_token_kind,
   output logic [28:0]      rsp_field_number,
   output logic [2:0]       rsp_wire_code,
   output logic [63:0]      rsp_value,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_field_end,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_message_done
);
   pbwt_pkg::token_type token, head;
   logic step;

   assign step = push && !full;

   pbwt_front #(
      .MAX_FIELD_NUMBER (MAX_FIELD_NUMBER),
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .in_byte       (req_in_byte),
      .end_of_message(req_end_of_message),
      .token         (token)
   );

   pbwt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (step),
      .push_data(token),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   assign rsp_token_kind   = head.token_kind;
   assign rsp_field_number = head.field_number;
   assign rsp_wire_code    = head.wire_code;
   assign rsp_value        = head.value;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_field_end    = head.field_end;
   assign rsp_error_code   = head.error_code;
   assign rsp_message_done = head.message_done;
endmodule
`default_nettype wire

// File: rtl/pbwt_front.sv
// ----------------------------------------------------------------------------
// pbwt_front
// Per-byte decode state machine: classifies each byte into one token.
// ----------------------------------------------------------------------------
`default_nettype none
module pbwt_front #(
   parameter logic [28:0] MAX_FIELD_NUMBER = 29'd536870911,
   parameter logic [31:0] MAX_MESSAGE_BYTES = 32'd65535
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 end_of_message,
   output pbwt_pkg::token_type       token
);
   pbwt_pkg::phase_type phase_ff, phase_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [28:0] field_ff, field_in;
   logic [2:0]  wt_ff, wt_in;
   logic [31:0] rem_ff, rem_in;

   logic        vdone, vovf;
   logic [63:0] vacc;
   logic [60:0] kf;
   logic [2:0]  kwt;
   logic [31:0] left;
   logic [2:0]  tok_kind;
   logic [2:0]  tok_err;

   always_comb begin
      vacc  = acc_ff;
      vovf  = 1'b0;
      vdone = 1'b0;
      if (cnt_ff >= 4'd9) begin
         vovf  = (in_byte[6:1] != 6'd0) || in_byte[7];
         vacc  = acc_ff | {in_byte[0], 63'd0};
         vdone = 1'b1;
      end else begin
         vacc  = acc_ff | ({57'd0, in_byte[6:0]} << (7 * cnt_ff));
         vdone = !in_byte[7];
      end
   end

   assign kf   = vacc[63:3];
   assign kwt  = vacc[2:0];
   assign left = (rem_ff == 32'd0) ? 32'd0 : rem_ff - 32'd1;

   // classify the byte
   always_comb begin
      tok_kind = pbwt_pkg::TK_NONE;
      tok_err  = pbwt_pkg::ERR_NONE;
      case (phase_ff)
         pbwt_pkg::PH_KEY, pbwt_pkg::PH_VARINT, pbwt_pkg::PH_LENGTH: begin
            if (vovf) begin
               tok_kind = pbwt_pkg::TK_ERROR;
               tok_err  = pbwt_pkg::ERR_OVERFLOW;
            end else if (!vdone) begin
               if (end_of_message) begin
                  tok_kind = pbwt_pkg::TK_ERROR;
                  tok_err  = pbwt_pkg::ERR_TRUNC;
               end
            end else if (phase_ff == pbwt_pkg::PH_KEY) begin
               if (kf == 61'd0 || kf > {32'd0, MAX_FIELD_NUMBER}) begin
                  tok_kind = pbwt_pkg::TK_ERROR;
                  tok_err  = pbwt_pkg::ERR_FIELD;
               end else if (!(kwt inside {pbwt_pkg::WT_VARINT, pbwt_pkg::WT_FIXED64,
                                          pbwt_pkg::WT_LEN, pbwt_pkg::WT_FIXED32})) begin
                  tok_kind = pbwt_pkg::TK_ERROR;
                  tok_err  = pbwt_pkg::ERR_WIRE;
               end else if (end_of_message) begin
                  tok_kind = pbwt_pkg::TK_ERROR;
                  tok_err  = pbwt_pkg::ERR_TRUNC;
               end else begin
                  tok_kind = pbwt_pkg::TK_KEY;
               end
            end else if (phase_ff == pbwt_pkg::PH_VARINT) begin
               tok_kind = pbwt_pkg::TK_VARINT;
            end else if (vacc > {32'd0, MAX_MESSAGE_BYTES} ||
                         (end_of_message && vacc != 64'd0)) begin
               tok_kind = pbwt_pkg::TK_ERROR;
               tok_err  = pbwt_pkg::ERR_TRUNC;
            end else begin
               tok_kind = pbwt_pkg::TK_LENGTH;
            end
         end
         pbwt_pkg::PH_PAYLOAD, pbwt_pkg::PH_FIXED: begin
            if (end_of_message && left != 32'd0) begin
               tok_kind = pbwt_pkg::TK_ERROR;
               tok_err  = pbwt_pkg::ERR_TRUNC;
            end else begin
               tok_kind = (phase_ff == pbwt_pkg::PH_PAYLOAD) ?
                          pbwt_pkg::TK_PAYLOAD : pbwt_pkg::TK_FIXED;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      field_in = field_ff;
      wt_in    = wt_ff;
      rem_in   = rem_ff;
      case (phase_ff)
         pbwt_pkg::PH_ERROR: begin
         end
         pbwt_pkg::PH_KEY, pbwt_pkg::PH_VARINT, pbwt_pkg::PH_LENGTH: begin
            if (tok_kind == pbwt_pkg::TK_ERROR) begin
               phase_in = pbwt_pkg::PH_ERROR;
            end else if (!vdone) begin
               acc_in = vacc;
               cnt_in = cnt_ff + 4'd1;
            end else if (tok_kind == pbwt_pkg::TK_KEY) begin
               cnt_in   = 4'd0;
               field_in = kf[28:0];
               wt_in    = kwt;
               acc_in   = 64'd0;
               if (kwt == pbwt_pkg::WT_VARINT) begin
                  phase_in = pbwt_pkg::PH_VARINT;
               end else if (kwt == pbwt_pkg::WT_LEN) begin
                  phase_in = pbwt_pkg::PH_LENGTH;
               end else begin
                  phase_in = pbwt_pkg::PH_FIXED;
                  rem_in   = (kwt == pbwt_pkg::WT_FIXED64) ? 32'd8 : 32'd4;
               end
            end else if (tok_kind == pbwt_pkg::TK_LENGTH && vacc != 64'd0) begin
               cnt_in   = 4'd0;
               acc_in   = 64'd0;
               phase_in = pbwt_pkg::PH_PAYLOAD;
               rem_in   = vacc[31:0];
            end else begin
               phase_in = pbwt_pkg::PH_KEY;
               acc_in   = 64'd0;
               cnt_in   = 4'd0;
               rem_in   = 32'd0;
            end
         end
         pbwt_pkg::PH_PAYLOAD, pbwt_pkg::PH_FIXED: begin
            if (tok_kind == pbwt_pkg::TK_ERROR) begin
               phase_in = pbwt_pkg::PH_ERROR;
            end else begin
               rem_in = left;
               if (left == 32'd0) begin
                  phase_in = pbwt_pkg::PH_KEY;
                  acc_in   = 64'd0;
                  cnt_in   = 4'd0;
               end
            end
         end
         default: begin
            phase_in = pbwt_pkg::PH_ERROR;
         end
      endcase
      if (end_of_message) begin
         phase_in = pbwt_pkg::PH_KEY;
         acc_in   = 64'd0;
         cnt_in   = 4'd0;
         rem_in   = 32'd0;
         field_in = 29'd0;
         wt_in    = 3'd0;
      end
   end

   // token fields
   always_comb begin
      token              = '0;
      token.token_kind   = tok_kind;
      token.error_code   = tok_err;
      token.message_done = end_of_message;
      case (tok_kind)
         pbwt_pkg::TK_KEY: begin
            token.field_number = kf[28:0];
            token.wire_code    = kwt;
         end
         pbwt_pkg::TK_VARINT: begin
            token.field_number = field_ff;
            token.wire_code    = wt_ff;
            token.value        = vacc;
            token.field_end    = 1'b1;
         end
         pbwt_pkg::TK_LENGTH: begin
            token.field_number = field_ff;
            token.wire_code    = wt_ff;
            token.value        = vacc;
            token.field_end    = (vacc == 64'd0);
         end
         pbwt_pkg::TK_PAYLOAD, pbwt_pkg::TK_FIXED: begin
            token.field_number = field_ff;
            token.wire_code    = wt_ff;
            token.data_byte    = in_byte;
            token.field_end    = (left == 32'd0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pbwt_pkg::PH_KEY;
         acc_ff   <= 64'd0;
         cnt_ff   <= 4'd0;
         field_ff <= 29'd0;
         wt_ff    <= 3'd0;
         rem_ff   <= 32'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         field_ff <= field_in;
         wt_ff    <= wt_in;
         rem_ff   <= rem_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/pbwt_queue.sv
// ----------------------------------------------------------------------------
// pbwt_queue
// Two-entry token queue between the decoder and the result port.
// ----------------------------------------------------------------------------
`default_nettype none
module pbwt_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire pbwt_pkg::token_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output pbwt_pkg::token_type       head
);
   pbwt_pkg::token_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head    = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign wp_in   = wp_ff ^ do_push;
   assign rp_in   = rp_ff ^ do_pop;
   assign cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// File: rtl/pbwt_checker.sv
// ----------------------------------------------------------------------------
// pbwt_checker
// Port-level checks for the wire tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "protobuf_wire_tokenizer_top_assert.svh"
module pbwt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        push,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [2:0]  rsp_token_kind,
   input wire logic [2:0]  rsp_error_code,
   input wire logic [63:0] rsp_value
);
   logic shown_err, shown_ok, shown_len, has_code, len_narrow, accepted;

   assign shown_err  = !empty && rsp_token_kind == pbwt_pkg::TK_ERROR;
   assign shown_ok   = !empty && rsp_token_kind != pbwt_pkg::TK_ERROR;
   assign shown_len  = !empty && rsp_token_kind == pbwt_pkg::TK_LENGTH;
   assign has_code   = rsp_error_code != pbwt_pkg::ERR_NONE;
   assign len_narrow = rsp_value[63:32] == 32'd0;
   assign accepted   = push && !full;

   `PWT_ASSERT_IMP(a_err_code, clock, reset, shown_err, has_code, "error token without code")
   `PWT_ASSERT_IMP(a_code_only_err, clock, reset, shown_ok, !has_code, "code on non-error token")
   `PWT_ASSERT_NEXT(a_push_fills, clock, reset, accepted, !empty, "accepted transaction lost")
   `PWT_ASSERT_IMP(a_len_bound, clock, reset, shown_len, len_narrow, "length above bound")
endmodule
bind protobuf_wire_tokenizer_top pbwt_checker u_pbwt_checker (
   .clock         (clock),
   .reset         (reset),
   .push          (push),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_token_kind(rsp_token_kind),
   .rsp_error_code(rsp_error_code),
   .rsp_value     (rsp_value)
);
`default_nettype wire
